// ----- src/paso_pkg.sv -----
// ----------------------------------------------------------------------------
// Phase accumulator sine oscillator package
// Field widths, defaults and the odd sine polynomial coefficients in Q30.
// ----------------------------------------------------------------------------
package paso_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FREQ_W          = 24;
    localparam int SR_W            = 18;

    localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

    // Q30 fraction width of the polynomial datapath
    localparam int QF = 30;

    // Index of the top odd coefficient (coefficients A1..A11)
    localparam logic [2:0] COEF_TOP = 3'd5;

    typedef logic [31:0] t_q30;

    // Taylor coefficients of sin(pi/2*x): index 0 is A1, index 5 is A11
    function automatic t_q30 sine_coef(input logic [2:0] idx);
        t_q30 c;
        unique case (idx)
            3'd0:    c = 32'd1686629713;
            3'd1:    c = 32'd693598668;
            3'd2:    c = 32'd85569305;
            3'd3:    c = 32'd5026995;
            3'd4:    c = 32'd172272;
            3'd5:    c = 32'd3864;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- src/phase_accumulator_sine_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// Phase accumulator sine oscillator core
// DDS numerically controlled oscillator: frequency to phase step, sine out.
// ----------------------------------------------------------------------------
// One input word is one sample tick. A nonzero frequency passes from
// acceptance to the result register through a restoring divider, which
// retires one quotient bit a cycle, the phase update and quadrant fold, a
// single 32x32 multiplier that evaluates the sine polynomial (seven
// products, each registered before it is used), and a round and saturate
// step that waits for a free output register. A zero frequency skips to a
// zero sample and leaves the phase alone. The input is stalled while a word
// is in flight; a finished sample waits in the output register while the
// next word is accepted.
module phase_accumulator_sine_oscillator_core
    import paso_pkg::*;
#(
    parameter int PHASE_BITS  = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [SR_W-1:0]               i_cfg_wdata,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [FREQ_W-1:0]             i_frequency,
    input  logic                          i_buffer_end,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_buffer_end_out
);

    localparam int DIV_STEPS = PHASE_BITS + 16;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int SH        = QF - (SAMPLE_BITS - 1);

    localparam logic [CNT_W-1:0]       DIV_LAST   = CNT_W'(DIV_STEPS - 1);
    localparam logic [32:0]            ROUND_HALF = 33'(64'd1 << (SH - 1));
    localparam logic [SAMPLE_BITS-1:0] SMAX       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [2:0] STEP_X2  = 3'd0;
    localparam logic [2:0] STEP_Y   = 3'd6;

    logic [2:0]             r_state;
    logic [SR_W-1:0]        r_sample_rate;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [CNT_W-1:0]       r_cnt;
    logic [DIV_STEPS-1:0]   r_dvd;
    logic [PHASE_BITS-1:0]  r_q;
    logic [SR_W-1:0]        r_rem;
    logic [30:0]            r_x;
    logic [1:0]             r_quad;
    logic [31:0]            r_x2;
    logic [31:0]            r_t;
    logic [63:0]            r_prod;
    logic [2:0]             r_step;
    logic                   r_zero;
    logic                   r_bend;
    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_bend_out;

    logic [SR_W-1:0]        divisor;
    logic [SR_W:0]          rem_sh;
    logic                   rem_ge;
    logic [SR_W:0]          rem_sub;
    logic [PHASE_BITS-1:0]  phase_sum;
    logic [PHASE_BITS+31:0] phase_ext;
    logic [31:0]            p32;
    logic [30:0]            x_fold;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [31:0]            prod_q30;
    logic [32:0]            y_rnd;
    logic [32:0]            s_full;
    logic [SAMPLE_BITS-1:0] s_sat;
    logic [SAMPLE_BITS-1:0] s_res;
    logic                   in_acc;
    logic                   out_free;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // divider datapath: one restoring step a cycle
    assign divisor = (r_sample_rate == '0) ? SR_W'(1) : r_sample_rate;
    assign rem_sh  = {r_rem, r_dvd[DIV_STEPS-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    // phase update and quadrant fold; normalise the phase to 32 bits
    assign phase_sum = r_phase + r_q;
    assign phase_ext = {phase_sum, 32'd0};
    assign p32       = phase_ext[PHASE_BITS+31 -: 32];
    assign x_fold    = p32[30] ? (31'(64'd1 << QF) - {1'b0, p32[29:0]})
                               : {1'b0, p32[29:0]};

    // shared multiplier operand select
    always_comb begin
        mul_a = r_t;
        mul_b = r_x2;
        if (r_step == STEP_X2) begin
            mul_a = {1'b0, r_x};
            mul_b = {1'b0, r_x};
        end else if (r_step == STEP_Y) begin
            mul_b = {1'b0, r_x};
        end
    end

    assign prod_q30 = r_prod[61:30];

    // round half up, saturate, apply sign or force a zero sample
    assign y_rnd  = {1'b0, r_t} + ROUND_HALF;
    assign s_full = y_rnd >> SH;
    assign s_sat  = (s_full > 33'(SMAX)) ? SMAX : s_full[SAMPLE_BITS-1:0];
    always_comb begin
        s_res = s_sat;
        if (r_zero) begin
            s_res = '0;
        end else if (r_quad[1]) begin
            s_res = '0 - s_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sample_rate <= SR_RESET;
            r_phase       <= '0;
            r_ovalid      <= 1'b0;
            r_cnt         <= '0;
            r_step        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_wdata;
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dvd  <= {i_frequency, (PHASE_BITS-8)'(0)};
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        r_zero <= (i_frequency == '0);
                        r_bend <= i_buffer_end;
                        r_state <= (i_frequency == '0) ? S_FIN : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sub[SR_W-1:0] : rem_sh[SR_W-1:0];
                    r_q   <= {r_q[PHASE_BITS-2:0], rem_ge};
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_phase <= phase_sum;
                    r_quad  <= p32[31:30];
                    r_x     <= x_fold;
                    r_step  <= STEP_X2;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 64'(mul_a) * 64'(mul_b);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_step == STEP_X2) begin
                        r_x2 <= prod_q30;
                        r_t  <= sine_coef(COEF_TOP);
                    end else if (r_step == STEP_Y) begin
                        r_t  <= prod_q30;
                    end else begin
                        // Horner step towards A1
                        r_t  <= sine_coef(COEF_TOP - r_step) - prod_q30;
                    end
                    if (r_step == STEP_Y) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step  <= r_step + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_sample   <= s_res;
            r_bend_out <= r_bend;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_sample         = r_sample;
    assign o_buffer_end_out = r_bend_out;

`ifndef SYNTHESIS
    a_nonzero_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_frequency != '0) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("nonzero frequency did not start the divider");

    a_zero_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_frequency == '0) |=> (r_state == S_FIN && $stable(r_phase)))
        else $error("zero frequency disturbed the phase");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < divisor))
        else $error("divider remainder not below divisor");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_UPD) |-> (r_step <= STEP_Y))
        else $error("polynomial step out of range");
`endif

endmodule

// ----- dv/tb_phase_accumulator_sine_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// Phase accumulator sine oscillator core testbench
// Drives sample ticks over several sample rates, with random gaps and stalls
// on both channels, and checks every sample word against a bit-true model of
// the phase divider, the accumulator and the Q30 sine polynomial.
// ----------------------------------------------------------------------------
module tb_phase_accumulator_sine_oscillator_core;
    import paso_pkg::*;

    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int PHASE_W   = PHASE_BITS_DEF;
    localparam int SETTLE    = PHASE_BITS_DEF + 48;
    localparam int HOLD_LEN  = 600;
    localparam int WDOG_MAX  = 4000;
    localparam longint unsigned POLY_A [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569305,
        64'd5026995, 64'd172272, 64'd3864
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                buffer_end;
    } t_tick_word;

    class nco_scoreboard;
        logic [SR_W-1:0]    rate      = SR_RESET;
        logic [PHASE_W-1:0] phase_acc = '0;
        t_tick_word         pending_samples [$];
        int                 errors    = 0;
        int                 checked   = 0;
        int                 silent    = 0;

        // Work out the sample word that one accepted tick causes
        function void note_tick(logic [FREQ_W-1:0] freq, logic last);
            t_tick_word      w;
            longint unsigned divisor, step, x, x2, t, y, s;
            logic [1:0]      quad;
            w.buffer_end = last;
            if (freq == '0) begin
                w.sample = '0;
                silent++;
            end else begin
                divisor   = (rate == '0) ? 64'd1 : 64'(rate);
                step      = ((64'(freq) << (PHASE_W - 8)) / divisor) & 64'hFFFF_FFFF;
                phase_acc = phase_acc + step[PHASE_W-1:0];
                quad      = phase_acc[31:30];
                x         = 64'(phase_acc[29:0]);
                // mirror the second and fourth quarter of the cycle
                if (quad[0]) x = (64'd1 << QF) - x;
                x2 = (x * x) >> QF;
                t  = POLY_A[5];
                for (int k = 4; k >= 0; k--) t = POLY_A[k] - ((t * x2) >> QF);
                y = (t * x) >> QF;
                s = (y + (64'd1 << (QF - SAMPLE_W))) >> (QF - SAMPLE_W + 1);
                if (s > (64'd1 << (SAMPLE_W - 1)) - 1) s = (64'd1 << (SAMPLE_W - 1)) - 1;
                if (quad[1]) s = 64'd0 - s;
                w.sample = s[SAMPLE_W-1:0];
            end
            pending_samples.push_back(w);
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] smp, logic last);
            t_tick_word w;
            if (pending_samples.size() == 0) begin
                $error("sample word with no tick waiting: sample %0d", $signed(smp));
                errors++;
                return;
            end
            w = pending_samples.pop_front();
            checked++;
            if (w.sample !== smp) begin
                $error("sample: expected %0d, got %0d", $signed(w.sample), $signed(smp));
                errors++;
            end
            if (w.buffer_end !== last) begin
                $error("buffer_end_out: expected %0b, got %0b", w.buffer_end, last);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_cfg_we         = 1'b0;
    logic [SR_W-1:0]            i_cfg_wdata      = '0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic [FREQ_W-1:0]          i_frequency      = '0;
    logic                       i_buffer_end     = 1'b0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_buffer_end_out;

    nco_scoreboard sb;
    bit            rx_gaps      = 1'b1;
    bit            hold_request = 1'b0;
    int            hold_left    = 0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;
    int            rate_settings = 0;

    phase_accumulator_sine_oscillator_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_frequency      (i_frequency),
        .i_buffer_end     (i_buffer_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sample         (o_sample),
        .o_buffer_end_out (o_buffer_end_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return FREQ_W'($urandom_range(1, 255));
            2:       return FREQ_W'(24'hFF_FFFF - $urandom_range(0, 255));
            3:       return FREQ_W'($urandom_range(20 * 256, 20000 * 256));
            default: return FREQ_W'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    // Offer one tick after an optional gap; return at the edge that takes it
    task automatic send_tick(logic [FREQ_W-1:0] freq, logic last, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frequency  <= freq;
        i_buffer_end <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Hold the input until every sample word is back and the core is quiet
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_rate(logic [SR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.rate = value;
        rate_settings++;
    endtask

    task automatic run_random(int count, bit gaps);
        for (int n = 0; n < count; n++) begin
            // pause the sender now and then until the output side drains
            if (n % 150 == 149) wait_idle();
            send_tick(pick_freq(), $urandom_range(0, 7) == 0, gaps ? idle_len() : 0);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (rx_gaps && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    // Monitor both channels and count cycles with no traffic
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_sample(o_sample, o_buffer_end_out);
            if (i_valid && !o_stall) sb.note_tick(i_frequency, i_buffer_end);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        if (quiet_cycles >= WDOG_MAX) begin
            $display("phase_accumulator_sine_oscillator_core verification failed");
            $finish;
        end
    end

    initial begin
        sb = new;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Divisor of one: each step only moves the top byte, so land on the
        // quarter-cycle boundaries exactly, including the saturating peak
        set_rate('0);
        for (int q = 0; q < 5; q++) send_tick(24'h00_0040, q[0], 0);
        send_tick(24'h00_0001, 1'b0, 0);
        send_tick(24'h00_0080, 1'b1, 0);
        send_tick(24'h00_00FF, 1'b0, 2);
        send_tick(24'hFF_FFFF, 1'b1, 0);
        send_tick(24'h00_0000, 1'b1, 0);
        wait_idle();

        // Field extremes at the nominal rate
        set_rate(18'd48000);
        send_tick(24'h00_0000, 1'b0, 0);
        send_tick(24'h00_0001, 1'b1, 0);
        send_tick(24'hFF_FFFF, 1'b0, 0);
        send_tick(24'd112640, 1'b0, 1);
        send_tick(24'h80_0000, 1'b1, 0);
        send_tick(24'h7F_FFFF, 1'b0, 0);
        send_tick(24'h00_0000, 1'b0, 0);
        wait_idle();

        set_rate(18'd8000);
        run_random(200, 1'b1);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering
        set_rate(18'd192000);
        hold_request = 1'b1;
        run_random(250, 1'b1);
        wait_idle();

        set_rate(18'h3_FFFF);
        run_random(200, 1'b1);
        wait_idle();

        // Back-to-back stretch: no idling on either side
        rx_gaps = 1'b0;
        set_rate(18'd44100);
        run_random(250, 1'b0);
        wait_idle();
        rx_gaps = 1'b1;

        set_rate(18'd1);
        run_random(150, 1'b1);
        wait_idle();

        for (int p = 0; p < 2; p++) begin
            set_rate(SR_W'($urandom_range(0, 18'h3_FFFF)));
            run_random(200, 1'b1);
            wait_idle();
        end

        $display("Checked %0d sample words (%0d silent ticks) over %0d sample-rate settings.",
                 sb.checked, sb.silent, rate_settings);
        $display("Included a %0d-cycle receiver hold-off and back-to-back stretches.", HOLD_LEN);
        if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
            $display("phase_accumulator_sine_oscillator_core verification clean");
        end else begin
            $display("phase_accumulator_sine_oscillator_core verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/paso_pkg.sv
src/phase_accumulator_sine_oscillator_core.sv
dv/tb_phase_accumulator_sine_oscillator_core.sv
